/* src/mtg_pkg.sv */
// Package for the MT19937 generator: table size, twist and tempering constants,
// action codes, queue entry and back-end types. No dependencies.
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int ADDR_W       = $clog2(STATE_WORDS);
  localparam int IDX_W        = $clog2(STATE_WORDS + 1);
  localparam int FAR_W        = $clog2(STATE_WORDS + TWIST_OFFSET);

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7FFF_FFFF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
  localparam logic [31:0] INIT_MULT    = 32'd1812433253;

  // action field codes
  localparam logic [1:0] ACT_RESEED = 2'd0;
  localparam logic [1:0] ACT_DRAW32 = 2'd1;
  localparam logic [1:0] ACT_DRAW64 = 2'd2;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_RESEED,
    OP_DRAW32,
    OP_DRAW64
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] seed;
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_ctl_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RS_MUL,
    B_RS_WR,
    B_DR_RD,
    B_DR_WAIT,
    B_OUT,
    B_TW_RD,
    B_TW_FAR,
    B_TW_WR
  } back_state_t;

endpackage

/* src/mtg_if.sv */
// Valid/ready channel interfaces for the MT19937 generator: request and result.
// No dependencies.
interface mtg_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] seed_value;

  modport source(output valid, action, seed_value, input ready);
  modport sink(input valid, action, seed_value, output ready);
endinterface

interface mtg_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_value;

  modport source(output valid, random_value, input ready);
  modport sink(input valid, random_value, output ready);
endinterface

/* src/mtg_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/mtg_front.sv */
// Front end: accepts request beats, drops unused action codes and queues commands.
// Depends on mtg_pkg and mtg_if.
module mtg_front (
  input  logic          clk,
  input  logic          rst,
  mtg_req_if.sink       req,
  output mtg_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);

  mtg_pkg::cmd_t                entries [mtg_pkg::QDEPTH];
  logic [mtg_pkg::QPTR_W-1:0]   wptr;
  logic [mtg_pkg::QPTR_W-1:0]   rptr;
  logic [mtg_pkg::QCNT_W-1:0]   count;
  logic                         is_cmd;
  mtg_pkg::op_t                 op;
  logic                         push;
  logic                         pop;

  always_comb begin
    is_cmd = 1'b1;
    op     = mtg_pkg::OP_RESEED;
    case (req.action)
      mtg_pkg::ACT_RESEED: op = mtg_pkg::OP_RESEED;
      mtg_pkg::ACT_DRAW32: op = mtg_pkg::OP_DRAW32;
      mtg_pkg::ACT_DRAW64: op = mtg_pkg::OP_DRAW64;
      default:             is_cmd = 1'b0;
    endcase
  end

  assign req.ready = (count != mtg_pkg::QCNT_W'(mtg_pkg::QDEPTH));
  // unused codes are taken and dropped
  assign push      = req.valid && req.ready && is_cmd;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == mtg_pkg::QPTR_W'(mtg_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == mtg_pkg::QPTR_W'(mtg_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= '{op: op, seed: req.seed_value};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= mtg_pkg::QCNT_W'(mtg_pkg::QDEPTH))
    else $error("command queue over-filled");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");

endmodule

/* src/mtg_back.sv */
// Back end: reseed, twist and draw sequencer over the state table RAM, with the
// result register. Depends on mtg_pkg and mtg_if.
module mtg_back (
  input  logic              clk,
  input  logic              rst,
  input  mtg_pkg::cmd_t     cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  output mtg_pkg::ram_ctl_t ram,
  input  logic [31:0]       rdata_a,
  input  logic [31:0]       rdata_b,
  mtg_rsp_if.source         rsp
);

  localparam logic [mtg_pkg::ADDR_W-1:0] LAST_POS  = mtg_pkg::ADDR_W'(mtg_pkg::STATE_WORDS - 1);
  localparam logic [mtg_pkg::IDX_W-1:0]  IDX_EMPTY = mtg_pkg::IDX_W'(mtg_pkg::STATE_WORDS);

  mtg_pkg::back_state_t          state, state_next;
  logic [mtg_pkg::IDX_W-1:0]     idx, idx_next;
  logic [mtg_pkg::ADDR_W-1:0]    pos, pos_next;
  logic [31:0]                   chain, chain_next;
  logic [31:0]                   prod, prod_next;
  logic [31:0]                   mix_y, mix_y_next;
  logic [31:0]                   upper, upper_next;
  logic                          is64, is64_next;
  logic                          half, half_next;
  logic [63:0]                   result, result_next;
  logic                          out_valid;
  logic [63:0]                   out_data;
  logic                          out_load;

  logic [mtg_pkg::ADDR_W-1:0]    pos_wrap;
  logic [mtg_pkg::FAR_W-1:0]     far_sum;
  logic [mtg_pkg::ADDR_W-1:0]    far;
  logic [31:0]                   seed_word;
  logic [31:0]                   word;

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  assign pos_wrap = (pos == LAST_POS) ? '0 : pos + 1'b1;
  assign far_sum  = mtg_pkg::FAR_W'(pos) + mtg_pkg::FAR_W'(mtg_pkg::TWIST_OFFSET);
  assign far      = (far_sum >= mtg_pkg::FAR_W'(mtg_pkg::STATE_WORDS))
                  ? mtg_pkg::ADDR_W'(far_sum - mtg_pkg::FAR_W'(mtg_pkg::STATE_WORDS))
                  : mtg_pkg::ADDR_W'(far_sum);
  assign seed_word = prod + 32'(pos);
  assign word      = temper(rdata_a);

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    pos_next    = pos;
    chain_next  = chain;
    prod_next   = prod;
    mix_y_next  = mix_y;
    upper_next  = upper;
    is64_next   = is64;
    half_next   = half;
    result_next = result;
    ram         = '0;
    cmd_pop     = 1'b0;
    out_load    = 1'b0;
    case (state)
      mtg_pkg::B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            mtg_pkg::OP_RESEED: begin
              ram.we     = 1'b1;
              ram.waddr  = '0;
              ram.wdata  = cmd.seed;
              chain_next = cmd.seed;
              pos_next   = mtg_pkg::ADDR_W'(1);
              state_next = mtg_pkg::B_RS_MUL;
            end
            mtg_pkg::OP_DRAW32, mtg_pkg::OP_DRAW64: begin
              is64_next  = (cmd.op == mtg_pkg::OP_DRAW64);
              half_next  = 1'b0;
              state_next = mtg_pkg::B_DR_RD;
            end
            default: ;
          endcase
        end
      end
      mtg_pkg::B_RS_MUL: begin
        prod_next  = mtg_pkg::INIT_MULT * (chain ^ (chain >> 30));
        state_next = mtg_pkg::B_RS_WR;
      end
      mtg_pkg::B_RS_WR: begin
        ram.we     = 1'b1;
        ram.waddr  = pos;
        ram.wdata  = seed_word;
        chain_next = seed_word;
        if (pos == LAST_POS) begin
          idx_next   = IDX_EMPTY;
          state_next = mtg_pkg::B_IDLE;
        end else begin
          pos_next   = pos + 1'b1;
          state_next = mtg_pkg::B_RS_MUL;
        end
      end
      mtg_pkg::B_DR_RD: begin
        if (idx == IDX_EMPTY) begin
          // table used up: regenerate before reading
          pos_next   = '0;
          state_next = mtg_pkg::B_TW_RD;
        end else begin
          ram.raddr_a = idx[mtg_pkg::ADDR_W-1:0];
          idx_next    = idx + 1'b1;
          state_next  = mtg_pkg::B_DR_WAIT;
        end
      end
      mtg_pkg::B_DR_WAIT: begin
        if (is64 && !half) begin
          upper_next = word;
          half_next  = 1'b1;
          state_next = mtg_pkg::B_DR_RD;
        end else begin
          result_next = is64 ? {upper, word} : {32'b0, word};
          state_next  = mtg_pkg::B_OUT;
        end
      end
      mtg_pkg::B_OUT: begin
        // hold until the result register is free
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = mtg_pkg::B_IDLE;
        end
      end
      mtg_pkg::B_TW_RD: begin
        ram.raddr_a = pos;
        ram.raddr_b = pos_wrap;
        state_next  = mtg_pkg::B_TW_FAR;
      end
      mtg_pkg::B_TW_FAR: begin
        mix_y_next  = (rdata_a & mtg_pkg::HIGH_BIT) | (rdata_b & mtg_pkg::LOW_BITS);
        ram.raddr_a = far;
        state_next  = mtg_pkg::B_TW_WR;
      end
      mtg_pkg::B_TW_WR: begin
        ram.we    = 1'b1;
        ram.waddr = pos;
        ram.wdata = rdata_a ^ (mix_y >> 1) ^ (mix_y[0] ? mtg_pkg::TWIST_MATRIX : 32'b0);
        if (pos == LAST_POS) begin
          idx_next   = '0;
          state_next = mtg_pkg::B_DR_RD;
        end else begin
          pos_next   = pos + 1'b1;
          state_next = mtg_pkg::B_TW_RD;
        end
      end
      default: state_next = mtg_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtg_pkg::B_IDLE;
      idx       <= IDX_EMPTY;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    chain  <= chain_next;
    prod   <= prod_next;
    mix_y  <= mix_y_next;
    upper  <= upper_next;
    is64   <= is64_next;
    half   <= half_next;
    result <= result_next;
    if (out_load) begin
      out_data <= result;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_data;

  a_twist_ends: assert property (@(posedge clk) disable iff (rst)
    (state == mtg_pkg::B_TW_WR && pos == LAST_POS)
      |=> (idx == '0 && state == mtg_pkg::B_DR_RD))
    else $error("twist did not rewind the read index");

  a_draw_reads: assert property (@(posedge clk) disable iff (rst)
    (state == mtg_pkg::B_DR_RD && idx != IDX_EMPTY) |=> state == mtg_pkg::B_DR_WAIT)
    else $error("draw with words left did not read the table");

  a_reseed_ends: assert property (@(posedge clk) disable iff (rst)
    (state == mtg_pkg::B_RS_WR && pos == LAST_POS)
      |=> (idx == IDX_EMPTY && state == mtg_pkg::B_IDLE))
    else $error("reseed did not leave the table marked used up");

endmodule

/* src/mersenne_twister_generator_unit.sv */
// MT19937 generator. Each request with a used action code is queued and run by a
// sequencer over one 624-word table RAM (one write port, two registered read ports).
// A reseed writes word 0, then a multiply stage and a write per further word, and
// gives no result. A draw reads and tempers a word (a 64-bit draw two, the first as
// the upper half) and loads the result register. Whenever the read index reaches the
// table end, the next read first runs the twist (read, far read, write per word).
// Draws before the first reseed return undefined data.
// Depends on mtg_pkg, mtg_if, mtg_ram, mtg_front and mtg_back.
module mersenne_twister_generator_unit (
  input  logic      clk,
  input  logic      rst,
  mtg_req_if.sink   req,
  mtg_rsp_if.source rsp
);

  mtg_pkg::cmd_t     cmd;
  logic              cmd_valid;
  logic              cmd_pop;
  mtg_pkg::ram_ctl_t ram;
  logic [31:0]       rdata_a;
  logic [31:0]       rdata_b;

  mtg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  mtg_ram #(
    .WIDTH (32),
    .DEPTH (mtg_pkg::STATE_WORDS)
  ) u_table (
    .clk     (clk),
    .we      (ram.we),
    .waddr   (ram.waddr),
    .wdata   (ram.wdata),
    .raddr_a (ram.raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (ram.raddr_b),
    .rdata_b (rdata_b)
  );

  mtg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .ram       (ram),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .rsp       (rsp)
  );

endmodule

/* tb/mtg_stream_checker.sv */
// Checker for the MT19937 generator: watches the request and result channels,
// keeps its own copy of the table and read index, and compares every result beat.
// Depends on mtg_pkg and mtg_if.
`timescale 1ns / 1ps

module mtg_stream_checker (
  input  logic clk,
  input  logic rst,
  mtg_req_if   req,
  mtg_rsp_if   rsp,
  output int   mismatches,
  output int   awaiting,
  output int   reseeds,
  output int   draws32,
  output int   draws64,
  output int   ignored,
  output int   twists,
  output int   results_seen
);

  logic [31:0] mt_table [0:mtg_pkg::STATE_WORDS-1];
  int unsigned mt_index;
  logic [63:0] due_randoms [$];

  int n_fail, n_reseed, n_d32, n_d64, n_ign, n_twist, n_res;

  initial begin
    foreach (mt_table[i]) mt_table[i] = '0;
    mt_index = mtg_pkg::STATE_WORDS;
    n_fail = 0;
    n_reseed = 0;
    n_d32 = 0;
    n_d64 = 0;
    n_ign = 0;
    n_twist = 0;
    n_res = 0;
  end

  function automatic void seed_mt_table(input logic [31:0] seed);
    logic [31:0] p;
    mt_table[0] = seed;
    for (int i = 1; i < mtg_pkg::STATE_WORDS; i++) begin
      p = mt_table[i-1];
      mt_table[i] = mtg_pkg::INIT_MULT * (p ^ (p >> 30)) + 32'(i);
    end
    mt_index = mtg_pkg::STATE_WORDS;
  endfunction

  function automatic void regenerate_mt_table();
    int nxt;
    int far;
    logic [31:0] y;
    for (int k = 0; k < mtg_pkg::STATE_WORDS; k++) begin
      nxt = (k + 1 < mtg_pkg::STATE_WORDS) ? k + 1 : 0;
      far = k + mtg_pkg::TWIST_OFFSET;
      if (far >= mtg_pkg::STATE_WORDS) far -= mtg_pkg::STATE_WORDS;
      y = (mt_table[k] & mtg_pkg::HIGH_BIT) | (mt_table[nxt] & mtg_pkg::LOW_BITS);
      mt_table[k] = mt_table[far] ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);
    end
    mt_index = 0;
    n_twist++;
  endfunction

  function automatic logic [31:0] next_tempered_word();
    logic [31:0] y;
    if (mt_index >= mtg_pkg::STATE_WORDS) regenerate_mt_table();
    y = mt_table[mt_index];
    mt_index++;
    y ^= (y >> 11);
    y ^= (y << 7) & mtg_pkg::TEMPER_B;
    y ^= (y << 15) & mtg_pkg::TEMPER_C;
    y ^= (y >> 18);
    return y;
  endfunction

  always @(posedge clk) begin
    logic [63:0] want;
    logic [31:0] hi;
    logic [31:0] lo;
    if (!rst) begin
      // results first: a beat leaving now belongs to an older request
      if (rsp.valid && rsp.ready) begin
        n_res++;
        if (due_randoms.size() == 0) begin
          n_fail++;
          $error("random_value: nothing expected, actual %h", rsp.random_value);
        end else begin
          want = due_randoms.pop_front();
          if (want !== rsp.random_value) begin
            n_fail++;
            $error("random_value: expected %h, actual %h", want, rsp.random_value);
          end
        end
      end
      if (req.valid && req.ready) begin
        case (req.action)
          mtg_pkg::ACT_RESEED: begin
            seed_mt_table(req.seed_value);
            n_reseed++;
          end
          mtg_pkg::ACT_DRAW32: begin
            due_randoms.push_back({32'd0, next_tempered_word()});
            n_d32++;
          end
          mtg_pkg::ACT_DRAW64: begin
            hi = next_tempered_word();
            lo = next_tempered_word();
            due_randoms.push_back({hi, lo});
            n_d64++;
          end
          default: n_ign++;
        endcase
      end
    end
    mismatches   <= n_fail;
    awaiting     <= due_randoms.size();
    reseeds      <= n_reseed;
    draws32      <= n_d32;
    draws64      <= n_d64;
    ignored      <= n_ign;
    twists       <= n_twist;
    results_seen <= n_res;
  end

endmodule

/* tb/tb_mersenne_twister_generator_unit.sv */
// Top of the MT19937 generator testbench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on mtg_pkg, mtg_if and mtg_stream_checker.
`timescale 1ns / 1ps

module tb_mersenne_twister_generator_unit;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 5 * mtg_pkg::STATE_WORDS + 16;

  logic clk;
  logic rst;

  mtg_req_if req_ch ();
  mtg_rsp_if rsp_ch ();

  int mismatches, awaiting, reseeds, draws32, draws64, ignored, twists, results_seen;

  mersenne_twister_generator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  mtg_stream_checker chk (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .mismatches   (mismatches),
    .awaiting     (awaiting),
    .reseeds      (reseeds),
    .draws32      (draws32),
    .draws64      (draws64),
    .ignored      (ignored),
    .twists       (twists),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // burst bookkeeping for the sender
  int burst_left;

  task automatic push_request(input logic [1:0] act, input logic [31:0] seed);
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.seed_value <= seed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic pause_requests(input int n);
    @(negedge clk);
    req_ch.valid      <= 1'b0;
    req_ch.action     <= 2'($urandom);
    req_ch.seed_value <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // open a new burst with a random gap in front when the current one runs out
  task automatic paced_push(input logic [1:0] act, input logic [31:0] seed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) pause_requests(gap);
    end
    burst_left--;
    push_request(act, seed);
  endtask

  function automatic logic [31:0] pick_seed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h0000_0000;
    if (r < 6) return 32'hFFFF_FFFF;
    if (r < 8) return 32'd5489;
    return $urandom;
  endfunction

  // sender
  initial begin
    int sent;
    int seg;
    int seg_len;
    int words;
    int r;
    bit straddle;
    logic [1:0] act;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.action     = mtg_pkg::ACT_RESEED;
    req_ch.seed_value = '0;
    burst_left        = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed: seed extremes, every action, unused code, back-to-back reseeds
    push_request(mtg_pkg::ACT_RESEED, 32'd5489);
    push_request(mtg_pkg::ACT_DRAW32, $urandom);
    push_request(mtg_pkg::ACT_DRAW32, $urandom);
    push_request(mtg_pkg::ACT_DRAW64, $urandom);
    push_request(mtg_pkg::ACT_DRAW64, $urandom);
    push_request(ACT_UNUSED, 32'hFFFF_FFFF);
    push_request(mtg_pkg::ACT_RESEED, 32'h0000_0000);
    push_request(mtg_pkg::ACT_DRAW64, 32'hFFFF_FFFF);
    push_request(mtg_pkg::ACT_DRAW32, 32'h0000_0000);
    push_request(mtg_pkg::ACT_RESEED, 32'hFFFF_FFFF);
    push_request(mtg_pkg::ACT_RESEED, 32'h8000_0000);
    push_request(mtg_pkg::ACT_DRAW32, $urandom);
    push_request(mtg_pkg::ACT_DRAW64, $urandom);
    push_request(ACT_UNUSED, 32'h0000_0000);
    push_request(mtg_pkg::ACT_RESEED, 32'd1);
    push_request(mtg_pkg::ACT_DRAW64, $urandom);
    push_request(mtg_pkg::ACT_DRAW32, $urandom);
    push_request(mtg_pkg::ACT_RESEED, 32'h7FFF_FFFF);
    push_request(mtg_pkg::ACT_DRAW32, $urandom);

    // random: each segment is a reseed followed by draws, a few long enough to
    // run past the end of the table, with stray codes and early reseeds mixed in
    sent = 0;
    seg  = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len  = (seg % 5 == 2) ? $urandom_range(450, 700) : $urandom_range(4, 40);
      straddle = $urandom_range(0, 1);
      paced_push(mtg_pkg::ACT_RESEED, pick_seed());
      sent++;
      words = 0;
      for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          paced_push(ACT_UNUSED, $urandom);
        end else begin
          if (r < 6) act = mtg_pkg::ACT_RESEED;
          else if (r < 53) act = mtg_pkg::ACT_DRAW32;
          else act = mtg_pkg::ACT_DRAW64;
          // make a 64-bit draw span the regeneration point
          if (straddle && act != mtg_pkg::ACT_RESEED &&
              words % mtg_pkg::STATE_WORDS == mtg_pkg::STATE_WORDS - 1)
            act = mtg_pkg::ACT_DRAW64;
          paced_push(act, (act == mtg_pkg::ACT_RESEED) ? pick_seed() : $urandom);
          sent++;
          case (act)
            mtg_pkg::ACT_RESEED: words = 0;
            mtg_pkg::ACT_DRAW32: words += 1;
            default:             words += 2;
          endcase
        end
      end
      seg++;
    end
    pause_requests(1);

    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d reseeds, %0d 32-bit and %0d 64-bit draws, %0d unused codes.",
             reseeds, draws32, draws64, ignored);
    $display("Table regenerated %0d times; %0d result beats compared.", twists, results_seen);
    if (mismatches == 0 && awaiting == 0) begin
      $display("mersenne_twister_generator_unit regression: pass");
    end else begin
      $display("mersenne_twister_generator_unit regression: fail");
    end
    $finish;
  end

  // receiver: changing ready patterns, plus two long hold-offs while a result waits
  initial begin
    int mode;
    int stretch;
    int hold_done;
    int hold_mark [2];
    rsp_ch.ready = 1'b0;
    hold_done    = 0;
    hold_mark[0] = 20;
    hold_mark[1] = 400;
    while (rst) @(negedge clk);
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(4, 60);
      repeat (stretch) begin
        @(negedge clk);
        if (hold_done < 2 && results_seen >= hold_mark[hold_done] && rsp_ch.valid) begin
          rsp_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          hold_done++;
        end else begin
          case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= ($urandom_range(0, 4) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
          endcase
        end
      end
    end
  end

  // watchdog: end the run after too long without any beat
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("mersenne_twister_generator_unit regression: fail");
    $finish;
  end

endmodule

/* sim.f */
src/mtg_pkg.sv
src/mtg_if.sv
src/mtg_ram.sv
src/mtg_front.sv
src/mtg_back.sv
src/mersenne_twister_generator_unit.sv
tb/mtg_stream_checker.sv
tb/tb_mersenne_twister_generator_unit.sv
